// File: hw/rtl/sicv_pkg.sv
package sicv_pkg;

    localparam int LENGTH_BITS = 48;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_EXTRA  = 2'd2;
    localparam logic [1:0] PH_CHUNK  = 2'd3;

    localparam logic [2:0] ST_VALID     = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_CHUNK_BAD = 3'd4;

    localparam logic [31:0] SIMG_MAGIC = 32'hED26_FF3A;
    localparam logic [15:0] KIND_RAW   = 16'hCAC1;
    localparam logic [15:0] KIND_FILL  = 16'hCAC2;
    localparam logic [15:0] KIND_SKIP  = 16'hCAC3;
    localparam logic [15:0] KIND_CRC   = 16'hCAC4;

    localparam logic [31:0] HEADER_BYTES       = 32'd28;
    localparam logic [31:0] CHUNK_HEADER_BYTES = 32'd12;

    typedef struct packed {
        logic [2:0]             status;
        logic [LENGTH_BITS-1:0] image_length;
        logic [15:0]            ver_major;
        logic [15:0]            ver_minor;
        logic [31:0]            block_size;
        logic [31:0]            total_blocks;
        logic [31:0]            declared_chunks;
        logic [31:0]            raw_chunks;
        logic [31:0]            fill_chunks;
        logic [31:0]            skip_chunks;
        logic [31:0]            crc_chunks;
        logic [31:0]            hdr_checksum;
    } result_t;

    function automatic logic [LENGTH_BITS-1:0] sat_add(
        input logic [LENGTH_BITS-1:0] len,
        input logic [31:0]            amt
    );
        logic [LENGTH_BITS:0] sum;
        begin
            sum = {1'b0, len} + {{(LENGTH_BITS-31){1'b0}}, amt};
            if (sum[LENGTH_BITS])
            begin
                sat_add = {LENGTH_BITS{1'b1}};
            end
            else
            begin
                sat_add = sum[LENGTH_BITS-1:0];
            end
        end
    endfunction

endpackage

// File: hw/rtl/sicv_if.sv
interface sicv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       start_flag;
    logic       end_flag;

    modport source (output valid, output byte_value, output start_flag, output end_flag,
                    input ready);
    modport sink (input valid, input byte_value, input start_flag, input end_flag,
                  output ready);
endinterface

interface sicv_out_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          status;
    logic [sicv_pkg::LENGTH_BITS-1:0]    image_length;
    logic [15:0]                         ver_major;
    logic [15:0]                         ver_minor;
    logic [31:0]                         block_size;
    logic [31:0]                         total_blocks;
    logic [31:0]                         declared_chunks;
    logic [31:0]                         raw_chunks;
    logic [31:0]                         fill_chunks;
    logic [31:0]                         skip_chunks;
    logic [31:0]                         crc_chunks;
    logic [31:0]                         hdr_checksum;

    modport source (output valid, output status, output image_length, output ver_major,
                    output ver_minor, output block_size, output total_blocks,
                    output declared_chunks, output raw_chunks, output fill_chunks,
                    output skip_chunks, output crc_chunks, output hdr_checksum,
                    input ready);
    modport sink (input valid, input status, input image_length, input ver_major,
                  input ver_minor, input block_size, input total_blocks,
                  input declared_chunks, input raw_chunks, input fill_chunks,
                  input skip_chunks, input crc_chunks, input hdr_checksum,
                  output ready);
endinterface

// File: hw/rtl/sicv_front.sv
module sicv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          byte_value,
    input  logic                start_flag,
    input  logic                end_flag,
    output logic                push,
    output sicv_pkg::result_t   result
);

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] idx_reg, idx_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] ver_reg, ver_next;
    logic [31:0] sizes_reg, sizes_next;
    logic [31:0] bsize_reg, bsize_next;
    logic [31:0] tblocks_reg, tblocks_next;
    logic [31:0] ccount_reg, ccount_next;
    logic [31:0] csum_reg, csum_next;
    logic [15:0] kind_reg, kind_next;
    logic [31:0] blocks_reg, blocks_next;
    logic [31:0] fsize_reg, fsize_next;
    logic        failed_reg, failed_next;
    logic [31:0] remain_reg, remain_next;
    logic [sicv_pkg::LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0] cnt_reg [4];
    logic [31:0] cnt_next [4];
    logic [63:0] prod_reg;

    logic        emit;
    logic [2:0]  emit_status;
    logic        with_len;
    logic        with_hdr;

    // product for the raw size check; operands settle well before the check byte
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(blocks_reg) * 64'(bsize_reg);
    end

    always_comb
    begin
        logic [1:0]  ph;
        logic [31:0] idx;
        logic [31:0] fhdr;
        logic [31:0] chdr;
        logic [31:0] payload;
        logic        range_bad;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        magic_next   = magic_reg;
        ver_next     = ver_reg;
        sizes_next   = sizes_reg;
        bsize_next   = bsize_reg;
        tblocks_next = tblocks_reg;
        ccount_next  = ccount_reg;
        csum_next    = csum_reg;
        kind_next    = kind_reg;
        blocks_next  = blocks_reg;
        fsize_next   = fsize_reg;
        failed_next  = failed_reg;
        remain_next  = remain_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        emit_status  = sicv_pkg::ST_VALID;
        with_len     = 1'b0;
        with_hdr     = 1'b0;
        ph           = phase_reg;
        idx          = idx_reg;
        fhdr         = 32'd0;
        chdr         = 32'd0;
        payload      = 32'd0;
        range_bad    = 1'b0;

        if (take)
        begin
            if (start_flag)
            begin
                idx_next     = 32'd0;
                magic_next   = 32'd0;
                ver_next     = 32'd0;
                sizes_next   = 32'd0;
                bsize_next   = 32'd0;
                tblocks_next = 32'd0;
                ccount_next  = 32'd0;
                csum_next    = 32'd0;
                kind_next    = 16'd0;
                blocks_next  = 32'd0;
                fsize_next   = 32'd0;
                failed_next  = 1'b0;
                remain_next  = 32'd0;
                len_next     = '0;
                for (int i = 0; i < 4; i++)
                begin
                    cnt_next[i] = 32'd0;
                end
                ph = sicv_pkg::PH_HEADER;
            end
            phase_next = ph;
            idx  = idx_next;
            fhdr = {16'd0, sizes_next[15:0]};
            chdr = {16'd0, sizes_next[31:16]};

            case (ph)
                sicv_pkg::PH_HEADER:
                begin
                    case (idx[4:2])
                        3'd0: magic_next[8*idx[1:0] +: 8]   = byte_value;
                        3'd1: ver_next[8*idx[1:0] +: 8]     = byte_value;
                        3'd2: sizes_next[8*idx[1:0] +: 8]   = byte_value;
                        3'd3: bsize_next[8*idx[1:0] +: 8]   = byte_value;
                        3'd4: tblocks_next[8*idx[1:0] +: 8] = byte_value;
                        3'd5: ccount_next[8*idx[1:0] +: 8]  = byte_value;
                        default: csum_next[8*idx[1:0] +: 8] = byte_value;
                    endcase
                    idx_next = idx + 32'd1;
                    fhdr = {16'd0, sizes_next[15:0]};
                    chdr = {16'd0, sizes_next[31:16]};
                    range_bad = (ver_next[15:0] != 16'd1) ||
                                (fhdr < sicv_pkg::HEADER_BYTES) ||
                                (chdr < sicv_pkg::CHUNK_HEADER_BYTES) ||
                                (bsize_next < 32'd4) || (bsize_next[1:0] != 2'd0) ||
                                (ccount_next == 32'd0);
                    if (idx_next == sicv_pkg::HEADER_BYTES)
                    begin
                        if (magic_next != sicv_pkg::SIMG_MAGIC)
                        begin
                            emit = 1'b1;
                            emit_status = sicv_pkg::ST_BAD_MAGIC;
                            with_hdr = 1'b1;
                        end
                        else if (range_bad)
                        begin
                            emit = 1'b1;
                            emit_status = sicv_pkg::ST_RANGE;
                            with_hdr = 1'b1;
                        end
                        else
                        begin
                            remain_next = ccount_next;
                            len_next = sicv_pkg::sat_add('0, fhdr);
                            idx_next = 32'd0;
                            kind_next = 16'd0;
                            blocks_next = 32'd0;
                            fsize_next = 32'd0;
                            failed_next = 1'b0;
                            phase_next = (fhdr > sicv_pkg::HEADER_BYTES) ?
                                         sicv_pkg::PH_EXTRA : sicv_pkg::PH_CHUNK;
                        end
                    end
                    else if (end_flag)
                    begin
                        emit = 1'b1;
                        emit_status = sicv_pkg::ST_TRUNCATED;
                    end
                end
                sicv_pkg::PH_EXTRA:
                begin
                    idx_next = idx + 32'd1;
                    if (idx_next >= fhdr - sicv_pkg::HEADER_BYTES)
                    begin
                        idx_next = 32'd0;
                        kind_next = 16'd0;
                        blocks_next = 32'd0;
                        fsize_next = 32'd0;
                        failed_next = 1'b0;
                        phase_next = sicv_pkg::PH_CHUNK;
                    end
                end
                sicv_pkg::PH_CHUNK:
                begin
                    if (idx < 32'd2)
                    begin
                        kind_next[8*idx[0] +: 8] = byte_value;
                    end
                    else if (idx >= 32'd4 && idx < 32'd8)
                    begin
                        blocks_next[8*idx[1:0] +: 8] = byte_value;
                    end
                    else if (idx >= 32'd8 && idx < 32'd12)
                    begin
                        fsize_next[8*idx[1:0] +: 8] = byte_value;
                    end
                    payload = fsize_next - chdr;
                    idx_next = idx + 32'd1;
                    if (idx == chdr - 32'd1 && fsize_next < chdr)
                    begin
                        emit = 1'b1;
                        emit_status = sicv_pkg::ST_CHUNK_BAD;
                    end
                    else
                    begin
                        if (idx == chdr - 32'd1)
                        begin
                            case (kind_next)
                                sicv_pkg::KIND_RAW:  failed_next = ({32'd0, payload} != prod_reg);
                                sicv_pkg::KIND_FILL: failed_next = (payload != 32'd4);
                                sicv_pkg::KIND_CRC:  failed_next = (payload != 32'd4);
                                sicv_pkg::KIND_SKIP: failed_next = (payload != 32'd0);
                                default:             failed_next = 1'b1;
                            endcase
                        end
                        if (idx >= chdr - 32'd1 && idx == fsize_next - 32'd1)
                        begin
                            if (kind_next >= sicv_pkg::KIND_RAW &&
                                kind_next <= sicv_pkg::KIND_CRC)
                            begin
                                cnt_next[kind_next[1:0] - 2'd1] =
                                    cnt_reg[kind_next[1:0] - 2'd1] + 32'd1;
                            end
                            if (failed_next)
                            begin
                                emit = 1'b1;
                                emit_status = sicv_pkg::ST_CHUNK_BAD;
                            end
                            else
                            begin
                                len_next = sicv_pkg::sat_add(len_reg, fsize_next);
                                remain_next = remain_reg - 32'd1;
                                if (remain_next == 32'd0)
                                begin
                                    emit = 1'b1;
                                    emit_status = sicv_pkg::ST_VALID;
                                end
                                else
                                begin
                                    idx_next = 32'd0;
                                    kind_next = 16'd0;
                                    blocks_next = 32'd0;
                                    fsize_next = 32'd0;
                                    failed_next = 1'b0;
                                end
                            end
                        end
                    end
                    if (emit)
                    begin
                        with_len = 1'b1;
                        with_hdr = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = sicv_pkg::PH_IDLE;
                end
            endcase

            // data ends past a good header: report the chunk as bad
            if (!emit && end_flag && phase_next != sicv_pkg::PH_IDLE)
            begin
                emit = 1'b1;
                emit_status = sicv_pkg::ST_CHUNK_BAD;
                with_len = 1'b1;
                with_hdr = 1'b1;
            end
            if (emit)
            begin
                phase_next = sicv_pkg::PH_IDLE;
            end
        end
    end

    assign push = emit;

    always_comb
    begin
        result.status          = emit_status;
        result.image_length    = with_len ? len_next : '0;
        result.ver_major       = with_hdr ? ver_next[15:0] : 16'd0;
        result.ver_minor       = with_hdr ? ver_next[31:16] : 16'd0;
        result.block_size      = with_hdr ? bsize_next : 32'd0;
        result.total_blocks    = with_hdr ? tblocks_next : 32'd0;
        result.declared_chunks = with_hdr ? ccount_next : 32'd0;
        result.raw_chunks      = with_len ? cnt_next[0] : 32'd0;
        result.fill_chunks     = with_len ? cnt_next[1] : 32'd0;
        result.skip_chunks     = with_len ? cnt_next[2] : 32'd0;
        result.crc_chunks      = with_len ? cnt_next[3] : 32'd0;
        result.hdr_checksum    = with_hdr ? csum_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sicv_pkg::PH_IDLE;
            idx_reg     <= 32'd0;
            magic_reg   <= 32'd0;
            ver_reg     <= 32'd0;
            sizes_reg   <= 32'd0;
            bsize_reg   <= 32'd0;
            tblocks_reg <= 32'd0;
            ccount_reg  <= 32'd0;
            csum_reg    <= 32'd0;
            kind_reg    <= 16'd0;
            blocks_reg  <= 32'd0;
            fsize_reg   <= 32'd0;
            failed_reg  <= 1'b0;
            remain_reg  <= 32'd0;
            len_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                cnt_reg[i] <= 32'd0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            magic_reg   <= magic_next;
            ver_reg     <= ver_next;
            sizes_reg   <= sizes_next;
            bsize_reg   <= bsize_next;
            tblocks_reg <= tblocks_next;
            ccount_reg  <= ccount_next;
            csum_reg    <= csum_next;
            kind_reg    <= kind_next;
            blocks_reg  <= blocks_next;
            fsize_reg   <= fsize_next;
            failed_reg  <= failed_next;
            remain_reg  <= remain_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/sicv_queue.sv
module sicv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sicv_pkg::result_t   push_data,
    output logic                full,
    sicv_out_if.source          out_bus
);

    sicv_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;
    sicv_pkg::result_t head;

    assign full = (count_reg == 2'd2);
    assign pop  = out_bus.valid && out_bus.ready;
    assign head = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign out_bus.valid           = (count_reg != 2'd0);
    assign out_bus.status          = head.status;
    assign out_bus.image_length    = head.image_length;
    assign out_bus.ver_major       = head.ver_major;
    assign out_bus.ver_minor       = head.ver_minor;
    assign out_bus.block_size      = head.block_size;
    assign out_bus.total_blocks    = head.total_blocks;
    assign out_bus.declared_chunks = head.declared_chunks;
    assign out_bus.raw_chunks      = head.raw_chunks;
    assign out_bus.fill_chunks     = head.fill_chunks;
    assign out_bus.skip_chunks     = head.skip_chunks;
    assign out_bus.crc_chunks      = head.crc_chunks;
    assign out_bus.hdr_checksum    = head.hdr_checksum;

endmodule

// File: hw/rtl/sparse_image_chunk_validator_unit.sv
// Accepts one byte per cycle whenever the result queue has room.
// A result appears on out_bus in the cycle after the byte that ends the parse.
// Throughput: one byte per clock; the parser keeps running while one result
// waits downstream, and the input stalls while two results wait.
// Reset (rst_n low, asynchronous) idles the parser and empties the queue.
module sparse_image_chunk_validator_unit (
    input  logic       clk,
    input  logic       rst_n,
    sicv_in_if.sink    in_bus,
    sicv_out_if.source out_bus
);

    logic              full;
    logic              take;
    logic              push;
    sicv_pkg::result_t result;

    assign in_bus.ready = !full;
    assign take = in_bus.valid && !full;

    sicv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .byte_value (in_bus.byte_value),
        .start_flag (in_bus.start_flag),
        .end_flag   (in_bus.end_flag),
        .push       (push),
        .result     (result)
    );

    sicv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .full      (full),
        .out_bus   (out_bus)
    );

endmodule

// File: hw/rtl/sicv_checker.sv
module sicv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [sicv_pkg::LENGTH_BITS-1:0] image_length,
    input logic [15:0] ver_major,
    input logic [31:0] declared_chunks,
    input logic [31:0] raw_chunks
);

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= sicv_pkg::ST_CHUNK_BAD))
        else $error("status code out of range");

    a_trunc_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sicv_pkg::ST_TRUNCATED) |->
        (image_length == '0 && ver_major == 16'd0 && declared_chunks == 32'd0))
        else $error("truncated header result carries fields");

    a_hdr_fail_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == sicv_pkg::ST_BAD_MAGIC || status == sicv_pkg::ST_RANGE))
        |-> (image_length == '0 && raw_chunks == 32'd0))
        else $error("header failure carries length or counts");

    a_valid_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == sicv_pkg::ST_VALID) |->
        (ver_major == 16'd1 && declared_chunks != 32'd0 && image_length >= 28))
        else $error("valid result with bad header fields");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)))
        else $error("stalled result changed");

endmodule

bind sparse_image_chunk_validator_unit sicv_checker u_sicv_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .status          (out_bus.status),
    .image_length    (out_bus.image_length),
    .ver_major       (out_bus.ver_major),
    .declared_chunks (out_bus.declared_chunks),
    .raw_chunks      (out_bus.raw_chunks)
);

// File: sim/sicv_tb_if.sv
`timescale 1ns / 1ps

// The block's interfaces come with the RTL; this file holds the testbench-side
// beat record used to describe one input byte.
package sicv_tb_types;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_flag;
        logic       end_flag;
    } byte_beat_t;

endpackage

// File: sim/sparse_image_chunk_validator_unit_tb.sv
`timescale 1ns / 1ps

module sparse_image_chunk_validator_unit_tb;

    logic clk;
    logic rst_n;
    sicv_in_if  in_bus ();
    sicv_out_if out_bus ();

    sparse_image_chunk_validator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_bus  (in_bus.sink),
        .out_bus (out_bus.source)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // parser shadow state
    logic [1:0]             p_phase;
    logic [31:0]            p_idx;
    logic [31:0]            p_magic;
    logic [31:0]            p_ver;
    logic [31:0]            p_sizes;
    logic [31:0]            p_bsize;
    logic [31:0]            p_tblocks;
    logic [31:0]            p_ccount;
    logic [31:0]            p_csum;
    logic [15:0]            p_kind;
    logic [31:0]            p_oblocks;
    logic [31:0]            p_fsize;
    logic                   p_failed;
    logic [31:0]            p_left;
    logic [sicv_pkg::LENGTH_BITS-1:0] p_len;
    logic [31:0]            p_cnt [4];

    sicv_pkg::result_t expected_results [$];
    int      fail_count;
    longint  cycle_count;
    sicv_tb_types::byte_beat_t stim [$];

    function automatic logic [31:0] put_b(logic [31:0] r, logic [7:0] b, logic [31:0] pos);
        return r | ({24'd0, b} << (8 * pos[1:0]));
    endfunction

    function automatic void grow_len(logic [31:0] amt);
        logic [sicv_pkg::LENGTH_BITS:0] s;
        s = {1'b0, p_len} + amt;
        p_len = s[sicv_pkg::LENGTH_BITS] ? {sicv_pkg::LENGTH_BITS{1'b1}} :
                                           s[sicv_pkg::LENGTH_BITS-1:0];
    endfunction

    function automatic void post_result(logic [2:0] st, bit with_len, bit with_hdr);
        sicv_pkg::result_t r;
        r = '0;
        r.status = st;
        if (with_len)
        begin
            r.image_length = p_len;
            r.raw_chunks   = p_cnt[0];
            r.fill_chunks  = p_cnt[1];
            r.skip_chunks  = p_cnt[2];
            r.crc_chunks   = p_cnt[3];
        end
        if (with_hdr)
        begin
            r.ver_major       = p_ver[15:0];
            r.ver_minor       = p_ver[31:16];
            r.block_size      = p_bsize;
            r.total_blocks    = p_tblocks;
            r.declared_chunks = p_ccount;
            r.hdr_checksum    = p_csum;
        end
        expected_results.push_back(r);
        p_phase = sicv_pkg::PH_IDLE;
    endfunction

    function automatic void clear_parse();
        p_idx = 0; p_magic = 0; p_ver = 0; p_sizes = 0; p_bsize = 0; p_tblocks = 0;
        p_ccount = 0; p_csum = 0; p_kind = 0; p_oblocks = 0; p_fsize = 0; p_failed = 0;
        p_left = 0; p_len = 0;
        for (int i = 0; i < 4; i++)
        begin
            p_cnt[i] = 0;
        end
    endfunction

    function automatic void clear_chunk();
        p_idx = 0; p_kind = 0; p_oblocks = 0; p_fsize = 0; p_failed = 0;
    endfunction

    function automatic void predict_byte(sicv_tb_types::byte_beat_t bt);
        logic [31:0] fh;
        logic [31:0] ch;
        logic [31:0] idx;
        logic [31:0] payload;
        logic [63:0] raw_need;
        if (bt.start_flag)
        begin
            clear_parse();
            p_phase = sicv_pkg::PH_HEADER;
        end
        if (p_phase == sicv_pkg::PH_IDLE)
            return;
        idx = p_idx;
        if (p_phase == sicv_pkg::PH_HEADER)
        begin
            case (idx >> 2)
                0: p_magic = put_b(p_magic, bt.byte_value, idx);
                1: p_ver = put_b(p_ver, bt.byte_value, idx);
                2: p_sizes = put_b(p_sizes, bt.byte_value, idx);
                3: p_bsize = put_b(p_bsize, bt.byte_value, idx);
                4: p_tblocks = put_b(p_tblocks, bt.byte_value, idx);
                5: p_ccount = put_b(p_ccount, bt.byte_value, idx);
                default: p_csum = put_b(p_csum, bt.byte_value, idx);
            endcase
            p_idx = idx + 1;
            if (p_idx == sicv_pkg::HEADER_BYTES)
            begin
                fh = {16'd0, p_sizes[15:0]};
                ch = {16'd0, p_sizes[31:16]};
                if (p_magic != sicv_pkg::SIMG_MAGIC)
                begin
                    post_result(sicv_pkg::ST_BAD_MAGIC, 0, 1);
                    return;
                end
                if (p_ver[15:0] != 16'd1 || fh < sicv_pkg::HEADER_BYTES
                    || ch < sicv_pkg::CHUNK_HEADER_BYTES
                    || p_bsize < 4 || p_bsize[1:0] != 2'd0 || p_ccount == 0)
                begin
                    post_result(sicv_pkg::ST_RANGE, 0, 1);
                    return;
                end
                p_left = p_ccount;
                p_len = 0;
                grow_len(fh);
                clear_chunk();
                p_phase = (fh > sicv_pkg::HEADER_BYTES) ? sicv_pkg::PH_EXTRA :
                                                          sicv_pkg::PH_CHUNK;
            end
            else if (bt.end_flag)
            begin
                post_result(sicv_pkg::ST_TRUNCATED, 0, 0);
                return;
            end
        end
        else if (p_phase == sicv_pkg::PH_EXTRA)
        begin
            fh = {16'd0, p_sizes[15:0]};
            p_idx = idx + 1;
            if (p_idx >= fh - sicv_pkg::HEADER_BYTES)
            begin
                clear_chunk();
                p_phase = sicv_pkg::PH_CHUNK;
            end
        end
        else
        begin
            ch = {16'd0, p_sizes[31:16]};
            if (idx < 2)
                p_kind = 16'(put_b({16'd0, p_kind}, bt.byte_value, idx));
            else if (idx >= 4 && idx < 8)
                p_oblocks = put_b(p_oblocks, bt.byte_value, idx);
            else if (idx >= 8 && idx < 12)
                p_fsize = put_b(p_fsize, bt.byte_value, idx);
            if (idx == ch - 1)
            begin
                if (p_fsize < ch)
                begin
                    post_result(sicv_pkg::ST_CHUNK_BAD, 1, 1);
                    return;
                end
                payload = p_fsize - ch;
                raw_need = 64'(p_oblocks) * 64'(p_bsize);
                case (p_kind)
                    sicv_pkg::KIND_RAW: p_failed = (64'(payload) != raw_need);
                    sicv_pkg::KIND_FILL, sicv_pkg::KIND_CRC: p_failed = (payload != 4);
                    sicv_pkg::KIND_SKIP: p_failed = (payload != 0);
                    default: p_failed = 1'b1;
                endcase
            end
            p_idx = idx + 1;
            if (idx >= ch - 1 && idx == p_fsize - 1)
            begin
                if (p_kind >= sicv_pkg::KIND_RAW && p_kind <= sicv_pkg::KIND_CRC)
                    p_cnt[p_kind[1:0] - 2'd1] += 1;
                if (p_failed)
                begin
                    post_result(sicv_pkg::ST_CHUNK_BAD, 1, 1);
                    return;
                end
                grow_len(p_fsize);
                p_left -= 1;
                if (p_left == 0)
                begin
                    post_result(sicv_pkg::ST_VALID, 1, 1);
                    return;
                end
                clear_chunk();
            end
        end
        if (bt.end_flag && p_phase != sicv_pkg::PH_IDLE)
            post_result(sicv_pkg::ST_CHUNK_BAD, 1, 1);
    endfunction

    // stream builders
    function automatic void push_b(logic [7:0] b, bit s = 0, bit e = 0);
        sicv_tb_types::byte_beat_t bt;
        bt.byte_value = b;
        bt.start_flag = s;
        bt.end_flag = e;
        stim.push_back(bt);
    endfunction

    function automatic void push_w(logic [31:0] w, int n, bit s = 0);
        for (int i = 0; i < n; i++)
        begin
            push_b(w[8*i +: 8], s && i == 0);
        end
    endfunction

    function automatic void push_hdr(logic [31:0] magic, logic [15:0] maj, logic [15:0] fh,
                                     logic [15:0] ch, logic [31:0] bs, logic [31:0] cc);
        push_w(magic, 4, 1);
        push_w({16'($urandom_range(0, 65535)), maj}, 4);
        push_w({ch, fh}, 4);
        push_w(bs, 4);
        push_w($urandom, 4);
        push_w(cc, 4);
        push_w($urandom, 4);
    endfunction

    function automatic logic [15:0] pick_kind();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 16'($urandom);
        case (k % 4)
            0: return sicv_pkg::KIND_RAW;
            1: return sicv_pkg::KIND_FILL;
            2: return sicv_pkg::KIND_SKIP;
            default: return sicv_pkg::KIND_CRC;
        endcase
    endfunction

    function automatic void push_chunk(logic [15:0] kind, logic [31:0] ch, logic [31:0] bs,
                                       bit good);
        logic [31:0] ob;
        logic [31:0] pay;
        ob = 0;
        case (kind)
            sicv_pkg::KIND_RAW:
            begin
                ob = $urandom_range(0, 2);
                pay = ob * bs;
            end
            sicv_pkg::KIND_FILL, sicv_pkg::KIND_CRC: pay = 4;
            sicv_pkg::KIND_SKIP:
            begin
                ob = $urandom;
                pay = 0;
            end
            default: pay = $urandom_range(0, 6);
        endcase
        if (!good)
            pay = $urandom_range(0, 9);
        push_w({16'($urandom_range(0, 65535)), kind}, 4);
        push_w(ob, 4);
        push_w(ch + pay, 4);
        for (int i = 12; i < ch + pay; i++)
        begin
            push_b(8'($urandom));
        end
    endfunction

    function automatic void push_image();
        logic [15:0] fh;
        logic [15:0] ch;
        logic [31:0] bs;
        int          n;
        fh = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(29, 34)) : 16'd28;
        ch = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(13, 16)) : 16'd12;
        bs = 4 * $urandom_range(1, 4);
        n = $urandom_range(1, 4);
        push_hdr(sicv_pkg::SIMG_MAGIC, 16'd1, fh, ch, bs, n);
        for (int i = 28; i < fh; i++)
        begin
            push_b(8'($urandom));
        end
        for (int i = 0; i < n; i++)
        begin
            push_chunk(pick_kind(), 32'(ch), bs, $urandom_range(0, 9) != 0);
        end
        // occasionally chop the tail and flag an early end
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n && stim.size() > 1; i++)
            begin
                void'(stim.pop_back());
            end
            stim[stim.size() - 1].end_flag = 1'b1;
        end
    endfunction

    // directed part: header fields, cut length, optional typed expectation
    typedef struct {
        logic [31:0] magic;
        logic [15:0] maj;
        logic [15:0] fh;
        logic [15:0] ch;
        logic [31:0] bs;
        logic [31:0] cc;
        int          cut;
        bit          typed;
        logic [2:0]  st;
    } dir_row_t;

    dir_row_t dir_rows [10] = '{
        '{32'hED26FF3A, 16'd1, 16'd28, 16'd12, 32'd4, 32'd1, 5, 1, sicv_pkg::ST_TRUNCATED},
        '{32'h00000000, 16'd1, 16'd28, 16'd12, 32'd4, 32'd1, 0, 1, sicv_pkg::ST_BAD_MAGIC},
        '{32'hFFFFFFFF, 16'd1, 16'd28, 16'd12, 32'd4, 32'd1, 0, 1, sicv_pkg::ST_BAD_MAGIC},
        '{32'hED26FF3A, 16'd2, 16'd28, 16'd12, 32'd4, 32'd1, 0, 1, sicv_pkg::ST_RANGE},
        '{32'hED26FF3A, 16'd1, 16'd27, 16'd12, 32'd4, 32'd1, 0, 1, sicv_pkg::ST_RANGE},
        '{32'hED26FF3A, 16'd1, 16'd28, 16'd11, 32'd4, 32'd1, 0, 1, sicv_pkg::ST_RANGE},
        '{32'hED26FF3A, 16'd1, 16'd28, 16'd12, 32'd6, 32'd1, 0, 1, sicv_pkg::ST_RANGE},
        '{32'hED26FF3A, 16'd1, 16'd28, 16'd12, 32'd0, 32'd1, 0, 1, sicv_pkg::ST_RANGE},
        '{32'hED26FF3A, 16'd1, 16'd28, 16'd12, 32'd4, 32'd0, 0, 1, sicv_pkg::ST_RANGE},
        '{32'hED26FF3A, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFC, 32'hFFFFFFFF, 0, 1,
          sicv_pkg::ST_RANGE}
    };

    // drive
    initial
    begin
        int gap;
        sicv_tb_types::byte_beat_t bt;
        in_bus.valid = 1'b0;
        in_bus.byte_value = '0;
        in_bus.start_flag = 1'b0;
        in_bus.end_flag = 1'b0;
        rst_n = 1'b0;
        fail_count = 0;
        p_phase = sicv_pkg::PH_IDLE;
        clear_parse();

        // idle noise, then a bare end flag before the real header
        push_b(8'hFF);
        push_b(8'h00, 0, 1);
        for (int r = 0; r < $size(dir_rows); r++)
        begin
            push_hdr(dir_rows[r].magic, dir_rows[r].maj, dir_rows[r].fh, dir_rows[r].ch,
                     dir_rows[r].bs, dir_rows[r].cc);
            if (dir_rows[r].cut > 0)
            begin
                while (stim.size() > 0 && stim[stim.size() - 1].start_flag == 1'b0
                       && dir_rows[r].cut < 28)
                begin
                    void'(stim.pop_back());
                    dir_rows[r].cut++;
                end
                stim[stim.size() - 1].end_flag = 1'b1;
            end
        end
        // a chunk shorter than its header, one of each kind plus an unknown kind, and a restart
        push_hdr(sicv_pkg::SIMG_MAGIC, 16'd1, 16'd28, 16'd12, 32'd4, 32'd1);
        push_w({16'd0, sicv_pkg::KIND_RAW}, 4);
        push_w(0, 4);
        push_w(5, 4);
        push_hdr(sicv_pkg::SIMG_MAGIC, 16'd1, 16'd28, 16'd12, 32'd8, 32'd5);
        push_chunk(sicv_pkg::KIND_RAW, 12, 8, 1);
        push_chunk(sicv_pkg::KIND_FILL, 12, 8, 1);
        push_chunk(sicv_pkg::KIND_SKIP, 12, 8, 1);
        push_chunk(sicv_pkg::KIND_CRC, 12, 8, 1);
        push_chunk(16'h1234, 12, 8, 1);
        push_hdr(sicv_pkg::SIMG_MAGIC, 16'd1, 16'd28, 16'd12, 32'd4, 32'd2);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase_sel = 0; phase_sel < 2; phase_sel++)
        begin
            while (stim.size() > 0)
            begin
                bt = stim.pop_front();
                gap = $urandom_range(0, 4);
                if (phase_sel == 1 && $urandom_range(0, 3) == 0)
                    gap = 0;
                repeat (gap) @(negedge clk);
                in_bus.valid = 1'b1;
                in_bus.byte_value = bt.byte_value;
                in_bus.start_flag = bt.start_flag;
                in_bus.end_flag = bt.end_flag;
                @(posedge clk);
                while (!in_bus.ready)
                    @(posedge clk);
                predict_byte(bt);
                @(negedge clk);
                in_bus.valid = 1'b0;
            end
            if (phase_sel == 0)
            begin
                // hold off until the block has drained
                while (expected_results.size() > 0)
                    @(negedge clk);
                while (stim.size() < 1090)
                begin
                    if ($urandom_range(0, 9) == 0)
                        push_b(8'($urandom), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                    else
                        push_image();
                end
                // long chunk count saturation is out of reach; extra junk header
                push_hdr($urandom, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                         $urandom);
                push_b(8'h00, 0, 1);
            end
        end
        while (expected_results.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("sparse_image_chunk_validator_unit regression: pass");
        else
            $display("sparse_image_chunk_validator_unit regression: fail");
        $finish;
    end

    // receive and check
    initial
    begin
        int stall;
        int rx_count;
        sicv_pkg::result_t got;
        sicv_pkg::result_t want;
        out_bus.ready = 1'b0;
        rx_count = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            out_bus.ready = 1'b0;
            repeat (stall) @(negedge clk);
            out_bus.ready = 1'b1;
            @(posedge clk);
            while (!out_bus.valid)
                @(posedge clk);
            got.status = out_bus.status;
            got.image_length = out_bus.image_length;
            got.ver_major = out_bus.ver_major;
            got.ver_minor = out_bus.ver_minor;
            got.block_size = out_bus.block_size;
            got.total_blocks = out_bus.total_blocks;
            got.declared_chunks = out_bus.declared_chunks;
            got.raw_chunks = out_bus.raw_chunks;
            got.fill_chunks = out_bus.fill_chunks;
            got.skip_chunks = out_bus.skip_chunks;
            got.crc_chunks = out_bus.crc_chunks;
            got.hdr_checksum = out_bus.hdr_checksum;
            // directed rows whose outcome is plain
            if (rx_count < $size(dir_rows) && dir_rows[rx_count].typed
                && got.status !== dir_rows[rx_count].st)
            begin
                $error("directed row %0d status expected %0d got %0d", rx_count,
                       dir_rows[rx_count].st, got.status);
                fail_count++;
            end
            rx_count++;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
                continue;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status expected %0d got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.image_length !== want.image_length)
            begin
                $error("image_length expected %0d got %0d", want.image_length,
                       got.image_length);
                fail_count++;
            end
            if (got.ver_major !== want.ver_major)
            begin
                $error("ver_major expected %0h got %0h", want.ver_major,
                       got.ver_major);
                fail_count++;
            end
            if (got.ver_minor !== want.ver_minor)
            begin
                $error("ver_minor expected %0h got %0h", want.ver_minor,
                       got.ver_minor);
                fail_count++;
            end
            if (got.block_size !== want.block_size)
            begin
                $error("block_size expected %0h got %0h", want.block_size, got.block_size);
                fail_count++;
            end
            if (got.total_blocks !== want.total_blocks)
            begin
                $error("total_blocks expected %0h got %0h", want.total_blocks,
                       got.total_blocks);
                fail_count++;
            end
            if (got.declared_chunks !== want.declared_chunks)
            begin
                $error("declared_chunks expected %0h got %0h", want.declared_chunks,
                       got.declared_chunks);
                fail_count++;
            end
            if (got.raw_chunks !== want.raw_chunks)
            begin
                $error("raw_chunks expected %0d got %0d", want.raw_chunks, got.raw_chunks);
                fail_count++;
            end
            if (got.fill_chunks !== want.fill_chunks)
            begin
                $error("fill_chunks expected %0d got %0d", want.fill_chunks, got.fill_chunks);
                fail_count++;
            end
            if (got.skip_chunks !== want.skip_chunks)
            begin
                $error("skip_chunks expected %0d got %0d", want.skip_chunks, got.skip_chunks);
                fail_count++;
            end
            if (got.crc_chunks !== want.crc_chunks)
            begin
                $error("crc_chunks expected %0d got %0d", want.crc_chunks, got.crc_chunks);
                fail_count++;
            end
            if (got.hdr_checksum !== want.hdr_checksum)
            begin
                $error("hdr_checksum expected %0h got %0h", want.hdr_checksum,
                       got.hdr_checksum);
                fail_count++;
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("sparse_image_chunk_validator_unit regression: fail");
                $finish;
            end
        end
    end

endmodule
